// File: rtl/ctcgd_pkg.sv
// shared widths, limits and result codes for the ctc greedy decoder
`timescale 1ns / 1ps
package ctcgd_pkg;

  localparam int PROB_W   = 16;
  localparam int CLS_W    = 13;
  localparam int LBL_W    = 14;
  localparam int SUM_W    = 24;
  localparam int CNT_W    = 9;

  localparam logic [CLS_W-1:0] POS_LIMIT = {CLS_W{1'b1}};
  localparam logic [SUM_W-1:0] SUM_MAX   = {SUM_W{1'b1}};
  localparam logic [CNT_W-1:0] CNT_MAX   = {CNT_W{1'b1}};
  localparam logic [LBL_W-1:0] LBL_RESET = 14'd8192;

  // restoring divider: one quotient bit per cycle
  localparam int DIV_STEPS = SUM_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

  localparam logic KIND_SYMBOL = 1'b0;
  localparam logic KIND_SCORE  = 1'b1;

endpackage

// File: rtl/ctcgd_div.sv
// iterative restoring divider for the sequence score, one bit per cycle
`timescale 1ns / 1ps
module ctcgd_div
  import ctcgd_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [SUM_W-1:0] dividend,
  input  logic [CNT_W-1:0] divisor,
  output logic             done,
  output logic [SUM_W-1:0] quotient
);

  logic [SUM_W-1:0]     quo_r, quo_nxt;
  logic [CNT_W-1:0]     rem_r, rem_nxt;
  logic [CNT_W-1:0]     dsr_r, dsr_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [CNT_W:0]       trial;
  logic [CNT_W:0]       diff;

  // shared subtract and compare
  assign trial = {rem_r, quo_r[SUM_W-1]};
  assign diff  = trial - {1'b0, dsr_r};

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dsr_nxt  = divisor;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, dsr_r}) begin
        rem_nxt = diff[CNT_W-1:0];
        quo_nxt = {quo_r[SUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[CNT_W-1:0];
        quo_nxt = {quo_r[SUM_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// File: rtl/ctc_greedy_decoder_core.sv
// ctc greedy decoder top level: step tracking, sequencer and result register
`timescale 1ns / 1ps
// Best-path decoder over a stream of class probabilities, one word per class.
// A class word that closes no step and no sequence is taken in S_IDLE, so
// such words stream at one per cycle. A step end that emits a symbol goes
// through S_SYM, which waits on out_stall for the result register. A
// sequence end adds the score: S_SCORE sets up, then S_DIV waits on the
// bit-serial restoring divider (24 quotient bits, sum over count) when
// symbols were emitted without error, and S_FIN loads the final result.
// in_stall is high while a word is being worked on. The label count
// register is written through the cfg port, which is always ready.
module ctc_greedy_decoder_core
  import ctcgd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [PROB_W-1:0] in_class_prob,
  input  logic              in_end_of_step,
  input  logic              in_end_of_sequence,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_kind,
  output logic [CLS_W-1:0]  out_label_index,
  output logic [PROB_W-1:0] out_avg_score,
  output logic              out_error,
  output logic              out_last,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [LBL_W-1:0]  cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SYM,
    S_SCORE,
    S_DIV,
    S_FIN
  } state_t;

  state_t            state_r, state_nxt;
  logic [LBL_W-1:0]  lbl_r, lbl_nxt;
  logic [PROB_W-1:0] best_prob_r, best_prob_nxt;
  logic [CLS_W-1:0]  best_idx_r, best_idx_nxt;
  logic [CLS_W-1:0]  pos_r, pos_nxt;
  logic [CLS_W-1:0]  prev_r, prev_nxt;
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              err_r, err_nxt;
  logic              eos_r, eos_nxt;
  logic [CLS_W-1:0]  sym_r, sym_nxt;
  logic [PROB_W-1:0] avg_r, avg_nxt;

  logic              ov_r, ov_nxt;
  logic              okind_r, okind_nxt;
  logic [CLS_W-1:0]  oidx_r, oidx_nxt;
  logic [PROB_W-1:0] oavg_r, oavg_nxt;
  logic              oerr_r, oerr_nxt;
  logic              olast_r, olast_nxt;

  logic              accept;
  logic              out_free;
  logic              take;
  logic [PROB_W-1:0] cand_prob;
  logic [CLS_W-1:0]  cand_idx;
  logic              eostep;
  logic [SUM_W:0]    sum_add;
  logic              div_start;
  logic              div_done;
  logic [SUM_W-1:0]  div_q;

  ctcgd_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_r),
    .divisor  (cnt_r),
    .done     (div_done),
    .quotient (div_q)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_free  = !ov_r || !out_stall;

  // running maximum, first maximum wins ties
  assign take      = (pos_r == '0) || (in_class_prob > best_prob_r);
  assign cand_prob = take ? in_class_prob : best_prob_r;
  assign cand_idx  = take ? pos_r : best_idx_r;
  assign eostep    = in_end_of_step || in_end_of_sequence;
  assign sum_add   = {1'b0, sum_r} + {{(SUM_W + 1 - PROB_W){1'b0}}, cand_prob};

  always_comb begin
    state_nxt     = state_r;
    lbl_nxt       = lbl_r;
    best_prob_nxt = best_prob_r;
    best_idx_nxt  = best_idx_r;
    pos_nxt       = pos_r;
    prev_nxt      = prev_r;
    sum_nxt       = sum_r;
    cnt_nxt       = cnt_r;
    err_nxt       = err_r;
    eos_nxt       = eos_r;
    sym_nxt       = sym_r;
    avg_nxt       = avg_r;
    ov_nxt        = ov_r && out_stall;
    okind_nxt     = okind_r;
    oidx_nxt      = oidx_r;
    oavg_nxt      = oavg_r;
    oerr_nxt      = oerr_r;
    olast_nxt     = olast_r;
    div_start     = 1'b0;

    if (cfg_valid) begin
      lbl_nxt = cfg_data;
    end

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          eos_nxt = in_end_of_sequence;
          if (eostep) begin
            prev_nxt      = cand_idx;
            pos_nxt       = '0;
            best_prob_nxt = '0;
            best_idx_nxt  = '0;
            if (cand_idx != '0 && cand_idx != prev_r) begin
              sym_nxt = cand_idx;
              if ({1'b0, cand_idx} >= lbl_r) begin
                err_nxt = 1'b1;
              end
              sum_nxt = sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0];
              if (cnt_r != CNT_MAX) begin
                cnt_nxt = cnt_r + 1'b1;
              end
              state_nxt = S_SYM;
            end else if (in_end_of_sequence) begin
              state_nxt = S_SCORE;
            end
          end else begin
            best_prob_nxt = cand_prob;
            best_idx_nxt  = cand_idx;
            if (pos_r != POS_LIMIT) begin
              pos_nxt = pos_r + 1'b1;
            end
          end
        end
      end
      S_SYM: begin
        if (out_free) begin
          ov_nxt    = 1'b1;
          okind_nxt = KIND_SYMBOL;
          oidx_nxt  = sym_r;
          oavg_nxt  = '0;
          oerr_nxt  = err_r;
          olast_nxt = 1'b0;
          state_nxt = eos_r ? S_SCORE : S_IDLE;
        end
      end
      S_SCORE: begin
        if (cnt_r == '0 || err_r) begin
          avg_nxt   = '0;
          state_nxt = S_FIN;
        end else begin
          div_start = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          // clamp a quotient that overflows the score width
          avg_nxt   = (div_q[SUM_W-1:PROB_W] != '0) ? {PROB_W{1'b1}} : div_q[PROB_W-1:0];
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          ov_nxt        = 1'b1;
          okind_nxt     = KIND_SCORE;
          oidx_nxt      = '0;
          oavg_nxt      = avg_r;
          oerr_nxt      = err_r;
          olast_nxt     = 1'b1;
          best_prob_nxt = '0;
          best_idx_nxt  = '0;
          pos_nxt       = '0;
          prev_nxt      = '0;
          sum_nxt       = '0;
          cnt_nxt       = '0;
          err_nxt       = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      lbl_r       <= LBL_RESET;
      best_prob_r <= '0;
      best_idx_r  <= '0;
      pos_r       <= '0;
      prev_r      <= '0;
      sum_r       <= '0;
      cnt_r       <= '0;
      err_r       <= 1'b0;
      eos_r       <= 1'b0;
      ov_r        <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      lbl_r       <= lbl_nxt;
      best_prob_r <= best_prob_nxt;
      best_idx_r  <= best_idx_nxt;
      pos_r       <= pos_nxt;
      prev_r      <= prev_nxt;
      sum_r       <= sum_nxt;
      cnt_r       <= cnt_nxt;
      err_r       <= err_nxt;
      eos_r       <= eos_nxt;
      ov_r        <= ov_nxt;
    end
    sym_r   <= sym_nxt;
    avg_r   <= avg_nxt;
    okind_r <= okind_nxt;
    oidx_r  <= oidx_nxt;
    oavg_r  <= oavg_nxt;
    oerr_r  <= oerr_nxt;
    olast_r <= olast_nxt;
  end

  assign out_valid       = ov_r;
  assign out_kind        = okind_r;
  assign out_label_index = oidx_r;
  assign out_avg_score   = oavg_r;
  assign out_error       = oerr_r;
  assign out_last        = olast_r;

endmodule

// File: dv/tb_ctc_greedy_decoder_core.sv
// self-checking testbench for the ctc greedy decoder core
`timescale 1ns / 1ps
module tb_ctc_greedy_decoder_core;
  import ctcgd_pkg::*;

  typedef struct packed {
    logic              kind;
    logic [CLS_W-1:0]  label;
    logic [PROB_W-1:0] score;
    logic              err;
    logic              seq_last;
  } decoded_word_t;

  // best-path decoder state, stepped once per accepted class word
  class decode_tracker;
    logic [LBL_W-1:0]  label_count;
    logic [PROB_W-1:0] best_prob;
    logic [CLS_W-1:0]  best_pos;
    logic [CLS_W-1:0]  class_pos;
    logic [CLS_W-1:0]  prev_pos;
    logic [SUM_W-1:0]  prob_sum;
    logic [CNT_W-1:0]  emit_count;
    logic              range_err;
    decoded_word_t     pending[$];
    int                failures;

    function new();
      label_count = LBL_RESET;
      failures = 0;
      clear_sequence();
    endfunction

    function void clear_sequence();
      best_prob = '0;
      best_pos = '0;
      class_pos = '0;
      prev_pos = '0;
      prob_sum = '0;
      emit_count = '0;
      range_err = 1'b0;
    endfunction

    function void note_word(logic [PROB_W-1:0] prob, logic step_end, logic seq_end);
      logic [SUM_W:0]   wide_sum;
      logic [SUM_W-1:0] quot;
      logic [PROB_W-1:0] avg;
      if (class_pos == '0 || prob > best_prob) begin
        best_prob = prob;
        best_pos = class_pos;
      end
      if (class_pos != POS_LIMIT) class_pos++;
      // a sequence end closes the open step too
      if (step_end || seq_end) begin
        if (best_pos != '0 && best_pos != prev_pos) begin
          if ({1'b0, best_pos} >= label_count) range_err = 1'b1;
          wide_sum = prob_sum + best_prob;
          prob_sum = (wide_sum > SUM_MAX) ? SUM_MAX : wide_sum[SUM_W-1:0];
          if (emit_count != CNT_MAX) emit_count++;
          pending.insert(pending.size(),
                         {KIND_SYMBOL, best_pos, {PROB_W{1'b0}}, range_err, 1'b0});
        end
        prev_pos = best_pos;
        class_pos = '0;
        best_prob = '0;
        best_pos = '0;
      end
      if (seq_end) begin
        avg = '0;
        if (emit_count != '0 && !range_err) begin
          quot = prob_sum / emit_count;
          avg = (quot > 24'hFFFF) ? 16'hFFFF : quot[PROB_W-1:0];
        end
        pending.insert(pending.size(), {KIND_SCORE, {CLS_W{1'b0}}, avg, range_err, 1'b1});
        clear_sequence();
      end
    endfunction

    function void check_word(decoded_word_t got);
      decoded_word_t want;
      if (pending.size() == 0) begin
        $display("%0t: result with none expected: kind %0d label %0d score %0d err %0d last %0d",
                 $time, got.kind, got.label, got.score, got.err, got.seq_last);
        failures++;
        return;
      end
      want = pending.pop_front();
      if (got.kind != want.kind) begin
        $display("%0t: kind expected %0d actual %0d", $time, want.kind, got.kind);
        failures++;
      end
      if (got.label != want.label) begin
        $display("%0t: label_index expected %0d actual %0d", $time, want.label, got.label);
        failures++;
      end
      if (got.score != want.score) begin
        $display("%0t: avg_score expected %0d actual %0d", $time, want.score, got.score);
        failures++;
      end
      if (got.err != want.err) begin
        $display("%0t: error expected %0d actual %0d", $time, want.err, got.err);
        failures++;
      end
      if (got.seq_last != want.seq_last) begin
        $display("%0t: last expected %0d actual %0d", $time, want.seq_last, got.seq_last);
        failures++;
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [PROB_W-1:0] in_class_prob = '0;
  logic              in_end_of_step = 1'b0;
  logic              in_end_of_sequence = 1'b0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic              out_kind;
  logic [CLS_W-1:0]  out_label_index;
  logic [PROB_W-1:0] out_avg_score;
  logic              out_error;
  logic              out_last;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [LBL_W-1:0]  cfg_data = '0;

  decode_tracker tracker = new();

  int                burst_left = 0;
  int                words_sent = 0;
  logic [PROB_W-1:0] last_prob = '0;
  int                stall_mode = 0;
  int                mode_left = 0;

  ctc_greedy_decoder_core DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_class_prob     (in_class_prob),
    .in_end_of_step    (in_end_of_step),
    .in_end_of_sequence(in_end_of_sequence),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_kind          (out_kind),
    .out_label_index   (out_label_index),
    .out_avg_score     (out_avg_score),
    .out_error         (out_error),
    .out_last          (out_last),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_data          (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // result side: check on accept, then stall on a mode that changes now and then
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      tracker.check_word({out_kind, out_label_index, out_avg_score, out_error, out_last});
    if (mode_left == 0) begin
      stall_mode <= $urandom_range(0, 2);
      mode_left <= $urandom_range(16, 160);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      default: out_stall <= ($urandom_range(0, 4) != 0);
    endcase
  end

  task automatic send_word(input logic [PROB_W-1:0] prob, input logic step_end,
                           input logic seq_end);
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
      burst_left = $urandom_range(1, 48);
    end
    in_valid <= 1'b1;
    in_class_prob <= prob;
    in_end_of_step <= step_end;
    in_end_of_sequence <= seq_end;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tracker.note_word(prob, step_end, seq_end);
    burst_left--;
    words_sent++;
  endtask

  // wait for every expected result, then cover a divide still in flight
  task automatic drain_block();
    in_valid <= 1'b0;
    burst_left = 0;
    while (tracker.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_label_count(input logic [LBL_W-1:0] value);
    drain_block();
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    tracker.label_count = value;
  endtask

  function automatic logic [PROB_W-1:0] pick_prob();
    logic [PROB_W-1:0] p;
    case ($urandom_range(0, 7))
      0: p = '0;
      1: p = 16'hFFFF;
      2: p = last_prob;  // tie with the previous class
      default: p = 16'($urandom);
    endcase
    last_prob = p;
    return p;
  endfunction

  task automatic random_sequence();
    int   steps;
    int   n;
    logic seq_close;
    logic step_mark;
    steps = $urandom_range(0, 6);
    if (steps == 0) begin
      send_word(pick_prob(), 1'($urandom_range(0, 1)), 1'b1);
      return;
    end
    for (int s = 0; s < steps; s++) begin
      n = ($urandom_range(0, 15) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
      for (int i = 0; i < n; i++) begin
        seq_close = (s == steps - 1) && (i == n - 1);
        step_mark = (i == n - 1) && (!seq_close || $urandom_range(0, 1));
        send_word(pick_prob(), step_mark, seq_close);
      end
    end
  endtask

  task automatic random_phase(input int word_target);
    int stop_at;
    stop_at = words_sent + word_target;
    while (words_sent < stop_at) begin
      if ($urandom_range(0, 7) == 0) begin
        // stray fragment that runs into the next sequence
        repeat ($urandom_range(1, 6))
          send_word(16'($urandom), 1'($urandom_range(0, 1)), 1'b0);
      end else begin
        random_sequence();
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: ties, repeats, blanks, sequence end inside a step, empty sequence
    write_label_count(LBL_RESET);
    send_word(16'h0000, 1'b0, 1'b0);
    send_word(16'hFFFF, 1'b0, 1'b0);
    send_word(16'hFFFF, 1'b1, 1'b0);
    send_word(16'h1234, 1'b0, 1'b0);
    send_word(16'h8000, 1'b1, 1'b0);
    send_word(16'hFFFF, 1'b1, 1'b0);
    send_word(16'h0001, 1'b0, 1'b0);
    send_word(16'h0002, 1'b1, 1'b0);
    send_word(16'h0000, 1'b0, 1'b0);
    send_word(16'h0000, 1'b0, 1'b0);
    send_word(16'h0001, 1'b0, 1'b1);
    send_word(16'hAAAA, 1'b0, 1'b1);
    send_word(16'h5555, 1'b1, 1'b1);

    // out-of-range index, then the error clears with the next sequence
    write_label_count(14'd2);
    send_word(16'h0000, 1'b0, 1'b0);
    send_word(16'h0000, 1'b0, 1'b0);
    send_word(16'hFFFF, 1'b1, 1'b0);
    send_word(16'h7FFF, 1'b1, 1'b1);
    send_word(16'h0000, 1'b0, 1'b0);
    send_word(16'h7FFF, 1'b1, 1'b1);

    write_label_count(14'd0);
    send_word(16'h0000, 1'b0, 1'b0);
    send_word(16'h0009, 1'b1, 1'b1);

    write_label_count(14'h3FFF);
    send_word(16'h0003, 1'b0, 1'b0);
    send_word(16'h0004, 1'b0, 1'b1);

    write_label_count(14'd1);
    send_word(16'h0000, 1'b0, 1'b0);
    send_word(16'h0100, 1'b1, 1'b1);

    // over-long step: class position saturates, late classes win under the top index
    write_label_count(LBL_RESET);
    for (int i = 0; i < 8200; i++)
      send_word((i == 8195) ? 16'hFFFF : 16'($urandom_range(0, 16'hFFFE)), i == 8199, 1'b0);
    send_word(16'h0100, 1'b1, 1'b1);

    // enough symbols to saturate both the sum and the symbol count
    for (int s = 0; s < 520; s++) begin
      send_word(16'h0000, 1'b0, 1'b0);
      if (s % 2 == 1) send_word(16'h0000, 1'b0, 1'b0);
      send_word(16'hFFFF, 1'b1, 1'b0);
    end
    send_word(16'h0000, 1'b0, 1'b1);

    random_phase(200);
    write_label_count(14'($urandom_range(1, 24)));
    random_phase(200);
    write_label_count(14'h3FFF);
    random_phase(200);
    write_label_count(14'd0);
    random_phase(150);
    write_label_count(14'($urandom_range(0, 14'h3FFF)));
    random_phase(250);

    drain_block();
    if (tracker.failures == 0 && tracker.pending.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #50_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
